@@ rtl/lru_key_value_cache_defines.svh @@
// Assertion macros shared by the checker of the LRU key-value cache.
// No dependencies; included by the checker file only.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication on clk, disabled while rst_n is low.
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, disabled while rst_n is low.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// Package of the LRU key-value cache: default sizes, controller states and
// the command and status structs between controller and datapath. No dependencies.
package lkvc_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  localparam int FIELD_W = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_RESP,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic decide;
    logic respond;
    logic sweep_rd;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_put;
    logic hit;
    logic slot_ok;
    logic idx_last;
  } dp_stat_t;

endpackage

@@ rtl/lkvc_ctrl.sv @@
// Controller of the LRU key-value cache: sequences scan, decision, rank sweep
// and commit for one item. Depends on lkvc_pkg.
module lkvc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lkvc_pkg::dp_stat_t stat_i,
  output lkvc_pkg::dp_cmd_t  cmd_o
);
  import lkvc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.idx_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        priority if (stat_i.hit && !stat_i.is_put) state_nxt = ST_RESP;
        else if (stat_i.hit) state_nxt = ST_SWEEP;
        else if (stat_i.is_put && stat_i.slot_ok) state_nxt = ST_SWEEP;
        else state_nxt = ST_IDLE;
      end
      ST_RESP: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (stat_i.idx_last) state_nxt = ST_SWEEP_END;
      end
      ST_SWEEP_END: begin
        // Only a put of a new key still has an entry to store.
        if (stat_i.is_put && !stat_i.hit) state_nxt = ST_COMMIT;
        else state_nxt = ST_IDLE;
      end
      ST_COMMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_SCAN:      cmd_o.scan_rd = 1'b1;
      ST_SCAN_END:  cmd_o = '0;
      ST_DECIDE: begin
        cmd_o.decide  = 1'b1;
        cmd_o.respond = !(stat_i.hit && !stat_i.is_put);
      end
      ST_RESP:      cmd_o.respond  = 1'b1;
      ST_SWEEP:     cmd_o.sweep_rd = 1'b1;
      ST_SWEEP_END: cmd_o = '0;
      ST_COMMIT:    cmd_o.commit = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/lkvc_datapath.sv @@
// Datapath of the LRU key-value cache: key, value and rank memories, valid
// bits, live count, capacity register and result registers. Depends on lkvc_pkg.
module lkvc_datapath #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkvc_pkg::dp_cmd_t             cmd_i,
  output lkvc_pkg::dp_stat_t            stat_o,
  input  logic                          in_command,
  input  logic [lkvc_pkg::FIELD_W-1:0]  in_lookup_key,
  input  logic [lkvc_pkg::FIELD_W-1:0]  in_store_value,
  input  logic                          cfg_valid,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [lkvc_pkg::FIELD_W-1:0]  out_value_out
);
  import lkvc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Memories; read data is registered.
  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [IDX_W-1:0]      rank_mem  [ENTRIES];
  logic [KEY_BITS-1:0]   key_q_r;
  logic [VALUE_BITS-1:0] val_q_r;
  logic [IDX_W-1:0]      rank_q_r;

  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   live_r;
  logic [CAP_W-1:0]   cap_r;

  // Item under work.
  logic                  put_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] eidx_r;
  logic             scan_ev_r;
  logic             sweep_wr_r;

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [IDX_W-1:0] hit_rank_r;
  logic             old_found_r;
  logic [IDX_W-1:0] old_idx_r;
  logic [IDX_W-1:0] old_rank_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic [IDX_W-1:0] tgt_r;
  logic [IDX_W-1:0] thr_r;
  logic             all_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [FIELD_W-1:0]    out_value_r;

  logic [63:0]           key_wide;
  logic [63:0]           val_wide;
  logic [63:0]           vq_wide;
  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [CMP_W-1:0]      live_ext;
  logic [CMP_W-1:0]      cap_ext;
  logic                  full;
  logic                  use_evict;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot;
  logic                  e_valid;
  logic [IDX_W-1:0]      rank_new;

  assign key_wide = {32'd0, in_lookup_key};
  assign val_wide = {32'd0, in_store_value};
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign val_in   = val_wide[VALUE_BITS-1:0];
  assign vq_wide  = 64'(val_q_r);

  // A capacity of zero acts as one; any value above the entry count acts as the entry count.
  assign live_ext = CMP_W'(live_r);
  assign cap_ext  = CMP_W'(cap_r);
  always_comb begin
    priority if (cap_r == '0) full = (live_r != '0);
    else if (cap_ext > CMP_W'(ENTRIES)) full = (live_ext >= CMP_W'(ENTRIES));
    else full = (live_ext >= cap_ext);
  end

  assign use_evict = full && old_found_r;
  assign slot_ok   = use_evict || free_found_r;
  assign slot      = use_evict ? old_idx_r : free_idx_r;

  assign stat_o.is_put   = put_r;
  assign stat_o.hit      = hit_r;
  assign stat_o.slot_ok  = slot_ok;
  assign stat_o.idx_last = (idx_r == IDX_W'(ENTRIES - 1));

  assign e_valid = valid_r[eidx_r];

  always_comb begin
    priority if (eidx_r == tgt_r) rank_new = '0;
    else if (e_valid && (all_r || (rank_q_r < thr_r))) rank_new = rank_q_r + IDX_W'(1);
    else rank_new = rank_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      put_r <= in_command;
      key_r <= key_in;
      val_r <= val_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      eidx_r     <= '0;
      scan_ev_r  <= 1'b0;
      sweep_wr_r <= 1'b0;
    end else begin
      scan_ev_r  <= cmd_i.scan_rd;
      sweep_wr_r <= cmd_i.sweep_rd;
      eidx_r     <= idx_r;
      if (cmd_i.load || cmd_i.decide) begin
        idx_r <= '0;
      end else if (cmd_i.scan_rd || cmd_i.sweep_rd) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Scan evaluation runs in the cycle after the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      old_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd_i.load) begin
      hit_r        <= 1'b0;
      old_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (scan_ev_r) begin
      if (e_valid && (key_q_r == key_r) && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= eidx_r;
        hit_rank_r <= rank_q_r;
      end
      if (e_valid && (!old_found_r || (rank_q_r > old_rank_r))) begin
        old_found_r <= 1'b1;
        old_idx_r   <= eidx_r;
        old_rank_r  <= rank_q_r;
      end
      if (!e_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= eidx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.decide) begin
      if (hit_r) begin
        tgt_r <= hit_idx_r;
        thr_r <= hit_rank_r;
        all_r <= 1'b0;
      end else begin
        tgt_r <= slot;
        thr_r <= '0;
        all_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r  <= '0;
    end else if (cmd_i.decide && put_r && !hit_r && use_evict) begin
      valid_r[slot] <= 1'b0;
      live_r        <= live_r - CNT_W'(1);
    end else if (cmd_i.commit) begin
      valid_r[tgt_r] <= 1'b1;
      live_r         <= live_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      key_mem[tgt_r] <= key_r;
    end
    if (cmd_i.scan_rd) begin
      key_q_r <= key_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.decide && put_r && hit_r) begin
      value_mem[hit_idx_r] <= val_r;
    end else if (cmd_i.commit) begin
      value_mem[tgt_r] <= val_r;
    end
    if (cmd_i.decide) begin
      val_q_r <= value_mem[hit_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_wr_r) begin
      rank_mem[eidx_r] <= rank_new;
    end
    if (cmd_i.scan_rd || cmd_i.sweep_rd) begin
      rank_q_r <= rank_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.respond) begin
      out_found_r <= hit_r;
      out_value_r <= (hit_r && !put_r) ? vq_wide[FIELD_W-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_value_out = out_value_r;

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: controller plus datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
// Usage: drive in_command (0 get, 1 put), in_lookup_key and in_store_value and
// raise start; the item is taken at a clock edge where start is high and busy
// is low. Busy then stays high until the item is fully processed.
// Each item gives exactly one result: out_valid is high for one cycle with
// out_found and out_value_out. The receiver cannot stall; results are simply
// presented once.
// The key and rank memories each have one read port and are scanned one entry
// per cycle. With N = ENTRIES, every item scans all N entries and then decides.
// A get miss, or a put that finds no slot, ends there; a put hit sweeps the N
// ranks, a get hit presents its result and then sweeps, and a put of a new key
// sweeps and then commits the entry. The result strobe is registered from the
// respond command of the decision state, or of the response state on a get hit.
// The capacity register is written through cfg_valid/cfg_data (always ready);
// the user must write it only while idle (not enforced); its reset value is 16.
// Synchronous reset empties the cache (valid bits and live count cleared);
// no clearing pass is needed.
module lru_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [lkvc_pkg::FIELD_W-1:0] in_lookup_key,
  input  logic [lkvc_pkg::FIELD_W-1:0] in_store_value,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [lkvc_pkg::FIELD_W-1:0] out_value_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data
);
  import lkvc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .in_store_value (in_store_value),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_value_out  (out_value_out)
  );

endmodule

@@ rtl/lkvc_checker.sv @@
// Port-level checker of the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_defines.svh.
`include "lru_key_value_cache_defines.svh"

module lkvc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_found,
  input logic [lkvc_pkg::FIELD_W-1:0] out_value_out
);

  // An accepted item keeps the block busy in the following cycle.
  `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // A result only follows a cycle in which an item was in work.
  `LKVC_ASSERT_SAME(a_result_in_work, out_valid, $past(busy), "result without an item in work")

  // A missing key never returns a value.
  `LKVC_ASSERT_SAME(a_miss_zero, out_valid && !out_found, out_value_out == '0, "value on a miss")

  // One item gives one result, so the strobe is never held high.
  `LKVC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held for two cycles")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
